FILE: hdl/otsm_pkg.sv
package otsm_pkg;

    // Number of bus lines the block drives, and the width of the tick counters.
    localparam int NUM_LINES  = 4;
    localparam int TICK_WIDTH = 12;

    // Fixed field widths.
    localparam int LINE_W  = 4;
    localparam int SEL_W   = 2;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 3;
    localparam int TEMP_W  = 16;

    localparam logic [LINE_W-1:0] LINE_MASK = LINE_W'((1 << NUM_LINES) - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_RESET   = 3'd7;

    typedef logic [TICK_WIDTH-1:0] t_tick;

    typedef struct packed {
        t_tick reset_low;
        t_tick presence_wait;
        t_tick slot_low;
        t_tick write_hold;
        t_tick read_sample;
        t_tick bit_gap;
        t_tick byte_gap;
        t_tick after_reset;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEL_W-1:0]  sensor_select;
        logic [LINE_W-1:0] line_levels;
    } t_item;

    typedef struct packed {
        logic [LINE_W-1:0] drive_low_mask;
        logic              busy_res;
        logic              done_res;
        logic              presence_fail;
        logic [TEMP_W-1:0] temperature_raw;
    } t_result;

    // Written register value, fitted to the tick width.
    function automatic t_tick to_tick(input logic [CFG_W-1:0] v);
        logic [CFG_W+TICK_WIDTH-1:0] w;
        w = {{TICK_WIDTH{1'b0}}, v};
        return w[TICK_WIDTH-1:0];
    endfunction

endpackage

FILE: hdl/otsm_if.sv
interface otsm_in_if
    import otsm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEL_W-1:0]  sensor_select;
    logic [LINE_W-1:0] line_levels;

    modport source (output valid, output mode, output sensor_select, output line_levels,
                    input ready);
    modport sink   (input valid, input mode, input sensor_select, input line_levels,
                    output ready);
endinterface

interface otsm_out_if
    import otsm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] drive_low_mask;
    logic              busy_res;
    logic              done_res;
    logic              presence_fail;
    logic [TEMP_W-1:0] temperature_raw;

    modport source (output valid, output drive_low_mask, output busy_res, output done_res,
                    output presence_fail, output temperature_raw, input ready);
    modport sink   (input valid, input drive_low_mask, input busy_res, input done_res,
                    input presence_fail, input temperature_raw, output ready);
endinterface

FILE: hdl/onewire_temp_sensor_master_unit.sv
// One-wire bus master for up to four temperature-sensor lines. Each input beat is one
// microsecond tick of bus time carrying a request code (none, start conversion, read
// temperature), the line that a new request addresses and the sampled level of every
// line; each input beat yields exactly one output beat with the pull-low mask for that
// tick, a busy flag, a done flag, a presence-failure flag and, on the finishing tick of a
// successful read, the raw 16-bit scratchpad temperature. A transaction sends a reset
// pulse, checks for presence, writes Skip ROM and then either Convert T or Read
// Scratchpad followed by two bytes read LSB first; all slot and gap lengths come from the
// eight tick-count registers, which the user must write only while the block is idle; the
// block does not enforce this. It takes one beat per clock cycle while the receiver keeps
// up: a beat is held in an input register, and the update of the phase, tick counter and
// shift word turns it into a registered result. That state update is what sets the rate.
module onewire_temp_sensor_master_unit
    import otsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    otsm_in_if.sink              i_in,
    otsm_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    step;
    logic    in_accept;

    // The held beat moves on whenever the output register is empty or being emptied,
    // so a new tick is taken every cycle while the far side keeps up.
    assign step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign in_accept = i_in.valid && i_in.ready;

    otsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    otsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .i_item  (r_item),
        .o_res   (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.mode          <= i_in.mode;
            r_item.sensor_select <= i_in.sensor_select;
            r_item.line_levels   <= i_in.line_levels;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.drive_low_mask  = r_res.drive_low_mask;
    assign o_out.busy_res        = r_res.busy_res;
    assign o_out.done_res        = r_res.done_res;
    assign o_out.presence_fail   = r_res.presence_fail;
    assign o_out.temperature_raw = r_res.temperature_raw;

endmodule

FILE: hdl/otsm_cfg.sv
module otsm_cfg
    import otsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= TICK_WIDTH'(480);
            r_cfg.presence_wait <= TICK_WIDTH'(60);
            r_cfg.slot_low      <= TICK_WIDTH'(2);
            r_cfg.write_hold    <= TICK_WIDTH'(58);
            r_cfg.read_sample   <= TICK_WIDTH'(12);
            r_cfg.bit_gap       <= TICK_WIDTH'(2);
            r_cfg.byte_gap      <= TICK_WIDTH'(10);
            r_cfg.after_reset   <= TICK_WIDTH'(400);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RESET_LOW:     r_cfg.reset_low     <= to_tick(i_cfg_data);
                CFG_PRESENCE_WAIT: r_cfg.presence_wait <= to_tick(i_cfg_data);
                CFG_SLOT_LOW:      r_cfg.slot_low      <= to_tick(i_cfg_data);
                CFG_WRITE_HOLD:    r_cfg.write_hold    <= to_tick(i_cfg_data);
                CFG_READ_SAMPLE:   r_cfg.read_sample   <= to_tick(i_cfg_data);
                CFG_BIT_GAP:       r_cfg.bit_gap       <= to_tick(i_cfg_data);
                CFG_BYTE_GAP:      r_cfg.byte_gap      <= to_tick(i_cfg_data);
                CFG_AFTER_RESET:   r_cfg.after_reset   <= to_tick(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/otsm_ctrl.sv
module otsm_ctrl
    import otsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_PRES_WAIT = 4'd2;
    localparam logic [3:0] PH_AFTER_RST = 4'd3;
    localparam logic [3:0] PH_WR_LOW    = 4'd4;
    localparam logic [3:0] PH_WR_HOLD   = 4'd5;
    localparam logic [3:0] PH_BIT_GAP   = 4'd6;
    localparam logic [3:0] PH_BYTE_GAP  = 4'd7;
    localparam logic [3:0] PH_RD_LOW    = 4'd8;
    localparam logic [3:0] PH_RD_WAIT   = 4'd9;

    localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    logic [3:0]        r_phase, n_phase, c_phase;
    t_tick             r_tick, n_tick, c_tick;
    logic [2:0]        r_bit, n_bit, c_bit;
    logic [1:0]        r_byte, n_byte, c_byte;
    logic [TEMP_W-1:0] r_shift, n_shift, c_shift;
    logic [SEL_W-1:0]  r_line, n_line, c_line;
    logic              r_read, n_read, c_read;

    logic              start;
    logic              drive;
    logic              done;
    logic              fail;
    logic              over;
    logic              level;
    logic              cmd_bit;
    logic [7:0]        cmd;
    t_tick             dur;
    logic [TICK_WIDTH:0] tick_inc;
    logic [LINE_W-1:0] levels_m;

    always_comb begin
        start = (r_phase == PH_IDLE)
             && (i_item.mode == MODE_CONVERT || i_item.mode == MODE_READ);

        // A new request makes this tick the first tick of the reset pulse.
        c_phase = start ? PH_RST_LOW : r_phase;
        c_tick  = start ? '0 : r_tick;
        c_bit   = start ? '0 : r_bit;
        c_byte  = start ? '0 : r_byte;
        c_shift = start ? '0 : r_shift;
        c_line  = start ? i_item.sensor_select : r_line;
        c_read  = start ? (i_item.mode == MODE_READ) : r_read;

        cmd = (c_byte == 2'd0) ? CMD_SKIP_ROM : (c_read ? CMD_READ_PAD : CMD_CONVERT);
        cmd_bit = cmd[c_bit];

        levels_m = i_item.line_levels & LINE_MASK;
        level    = levels_m[c_line];

        drive = 1'b0;
        dur   = '0;
        n_phase = c_phase;
        case (c_phase)
            PH_IDLE:      dur = '0;
            PH_RST_LOW:   begin drive = 1'b1; dur = i_cfg.reset_low; end
            PH_PRES_WAIT: dur = i_cfg.presence_wait;
            PH_AFTER_RST: dur = i_cfg.after_reset;
            PH_WR_LOW:    begin drive = 1'b1; dur = i_cfg.slot_low; end
            PH_WR_HOLD:   begin drive = !cmd_bit; dur = i_cfg.write_hold; end
            PH_BIT_GAP:   dur = i_cfg.bit_gap;
            PH_BYTE_GAP:  dur = i_cfg.byte_gap;
            PH_RD_LOW:    begin drive = 1'b1; dur = i_cfg.slot_low; end
            PH_RD_WAIT:   dur = i_cfg.read_sample;
            default:      n_phase = PH_IDLE;
        endcase

        tick_inc = {1'b0, c_tick} + 1'b1;
        over = (dur == '0) || (tick_inc >= {1'b0, dur});

        n_tick  = c_tick;
        n_bit   = c_bit;
        n_byte  = c_byte;
        n_shift = c_shift;
        n_line  = c_line;
        n_read  = c_read;
        done = 1'b0;
        fail = 1'b0;

        if (n_phase != PH_IDLE) begin
            if (!over) begin
                n_tick = tick_inc[TICK_WIDTH-1:0];
            end else begin
                n_tick = '0;
                case (c_phase)
                    PH_RST_LOW: n_phase = PH_PRES_WAIT;
                    PH_PRES_WAIT: begin
                        if (level) begin
                            done = 1'b1;
                            fail = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_AFTER_RST;
                        end
                    end
                    PH_AFTER_RST: begin
                        n_bit = '0;
                        n_byte = '0;
                        n_phase = PH_WR_LOW;
                    end
                    PH_WR_LOW:  n_phase = PH_WR_HOLD;
                    PH_WR_HOLD: n_phase = PH_BIT_GAP;
                    PH_RD_LOW:  n_phase = PH_RD_WAIT;
                    PH_RD_WAIT: begin
                        if (level && c_byte[1]) begin
                            n_shift = c_shift | (TEMP_W'(1) << {c_byte[0], c_bit});
                        end
                        n_phase = PH_BIT_GAP;
                    end
                    PH_BIT_GAP: begin
                        if (c_bit != 3'd7) begin
                            n_bit = c_bit + 3'd1;
                            n_phase = c_byte[1] ? PH_RD_LOW : PH_WR_LOW;
                        end else begin
                            n_bit = '0;
                            if (c_byte == 2'd3 || (c_byte == 2'd1 && !c_read)) begin
                                done = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_BYTE_GAP;
                            end
                        end
                    end
                    PH_BYTE_GAP: begin
                        n_byte = c_byte + 2'd1;
                        n_phase = n_byte[1] ? PH_RD_LOW : PH_WR_LOW;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end

        o_res.drive_low_mask  = drive ? ((LINE_W'(1) << c_line) & LINE_MASK) : '0;
        o_res.busy_res        = (n_phase != PH_IDLE);
        o_res.done_res        = done;
        o_res.presence_fail   = fail;
        o_res.temperature_raw = (done && !fail && c_read) ? c_shift : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_line  <= '0;
            r_read  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_line  <= n_line;
            r_read  <= n_read;
        end
    end

endmodule

FILE: tb/otsm_tb_pkg.sv
package otsm_tb_pkg;

    import otsm_pkg::*;

    // Request codes carried in the mode field of an input beat.
    typedef enum logic [MODE_W-1:0] {
        REQ_NONE     = 2'd0,
        REQ_CONVERT  = 2'd1,
        REQ_READ     = 2'd2,
        REQ_RESERVED = 2'd3
    } t_request;

endpackage

FILE: tb/otsm_checker.sv
module otsm_checker
    import otsm_pkg::*;
    import otsm_tb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    otsm_in_if                   i_in,
    otsm_out_if                  i_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_failures,
    output int                   o_pending,
    output logic                 o_bus_idle,
    output logic                 o_presence_window,
    output logic [SEL_W-1:0]     o_active_line
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_RST_LOW,
        BUS_PRES_WAIT,
        BUS_AFTER_RST,
        BUS_WR_LOW,
        BUS_WR_HOLD,
        BUS_BIT_GAP,
        BUS_BYTE_GAP,
        BUS_RD_LOW,
        BUS_RD_WAIT
    } t_bus_phase;

    localparam t_cfg TIMING_AT_RESET = '{
        reset_low:     t_tick'(480),
        presence_wait: t_tick'(60),
        slot_low:      t_tick'(2),
        write_hold:    t_tick'(58),
        read_sample:   t_tick'(12),
        bit_gap:       t_tick'(2),
        byte_gap:      t_tick'(10),
        after_reset:   t_tick'(400)
    };

    t_cfg        timing;
    t_bus_phase  bus_phase;
    t_tick       tick_cnt;
    logic [2:0]  bit_idx;
    logic [1:0]  byte_idx;
    logic [15:0] temp_shift;
    logic [SEL_W-1:0] line;
    logic        read_txn;

    // Bus beats still owed by the block, oldest first.
    t_result expected_ticks[$];

    assign o_bus_idle        = (bus_phase == BUS_IDLE);
    assign o_presence_window = (bus_phase == BUS_PRES_WAIT);
    assign o_active_line     = line;

    function automatic logic slot_expired(input t_tick span);
        return (span == '0) || ((TICK_WIDTH + 1)'(tick_cnt) + 1'b1 >= (TICK_WIDTH + 1)'(span));
    endfunction

    function automatic logic command_bit();
        logic [7:0] cmd;
        if (byte_idx == 2'd0) begin
            cmd = CMD_SKIP_ROM;
        end else if (read_txn) begin
            cmd = CMD_READ_PAD;
        end else begin
            cmd = CMD_CONVERT;
        end
        return cmd[bit_idx];
    endfunction

    function automatic logic line_level(input logic [LINE_W-1:0] levels);
        logic [LINE_W-1:0] seen;
        seen = levels & LINE_MASK;
        return seen[line];
    endfunction

    task automatic enter(input t_bus_phase next);
        bus_phase = next;
        tick_cnt  = '0;
    endtask

    // Advances the bus by one microsecond and queues the beat it should produce.
    task automatic predict_tick(input t_item it);
        t_result r;
        t_tick   span;
        logic    pull;
        r    = '0;
        span = '0;
        pull = 1'b0;
        if (bus_phase == BUS_IDLE && (it.mode == REQ_CONVERT || it.mode == REQ_READ)) begin
            line       = it.sensor_select;
            read_txn   = (it.mode == REQ_READ);
            temp_shift = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            enter(BUS_RST_LOW);
        end

        case (bus_phase)
            BUS_RST_LOW: begin
                pull = 1'b1;
                span = timing.reset_low;
            end
            BUS_PRES_WAIT: span = timing.presence_wait;
            BUS_AFTER_RST: span = timing.after_reset;
            BUS_WR_LOW: begin
                pull = 1'b1;
                span = timing.slot_low;
            end
            BUS_WR_HOLD: begin
                pull = !command_bit();
                span = timing.write_hold;
            end
            BUS_BIT_GAP: span = timing.bit_gap;
            BUS_BYTE_GAP: span = timing.byte_gap;
            BUS_RD_LOW: begin
                pull = 1'b1;
                span = timing.slot_low;
            end
            BUS_RD_WAIT: span = timing.read_sample;
            default: bus_phase = BUS_IDLE;
        endcase

        if (bus_phase != BUS_IDLE) begin
            if (!slot_expired(span)) begin
                tick_cnt = tick_cnt + 1'b1;
            end else begin
                case (bus_phase)
                    BUS_RST_LOW: enter(BUS_PRES_WAIT);
                    BUS_PRES_WAIT: begin
                        if (line_level(it.line_levels)) begin
                            r.done_res      = 1'b1;
                            r.presence_fail = 1'b1;
                            enter(BUS_IDLE);
                        end else begin
                            enter(BUS_AFTER_RST);
                        end
                    end
                    BUS_AFTER_RST: begin
                        bit_idx  = '0;
                        byte_idx = '0;
                        enter(BUS_WR_LOW);
                    end
                    BUS_WR_LOW: enter(BUS_WR_HOLD);
                    BUS_WR_HOLD: enter(BUS_BIT_GAP);
                    BUS_RD_LOW: enter(BUS_RD_WAIT);
                    BUS_RD_WAIT: begin
                        // Bytes two and three fill the low and high halves of the word.
                        if (line_level(it.line_levels) && byte_idx >= 2'd2) begin
                            temp_shift[{byte_idx[0], bit_idx}] = 1'b1;
                        end
                        enter(BUS_BIT_GAP);
                    end
                    BUS_BIT_GAP: begin
                        if (bit_idx < 3'd7) begin
                            bit_idx = bit_idx + 1'b1;
                            enter(byte_idx < 2'd2 ? BUS_WR_LOW : BUS_RD_LOW);
                        end else begin
                            bit_idx = '0;
                            if (byte_idx == 2'd3 || (byte_idx == 2'd1 && !read_txn)) begin
                                r.done_res = 1'b1;
                                if (read_txn) begin
                                    r.temperature_raw = temp_shift;
                                end
                                enter(BUS_IDLE);
                            end else begin
                                enter(BUS_BYTE_GAP);
                            end
                        end
                    end
                    BUS_BYTE_GAP: begin
                        byte_idx = byte_idx + 1'b1;
                        enter(byte_idx < 2'd2 ? BUS_WR_LOW : BUS_RD_LOW);
                    end
                    default: enter(BUS_IDLE);
                endcase
            end
        end

        r.drive_low_mask = pull ? (LINE_MASK & (LINE_W'(1) << line)) : '0;
        r.busy_res       = (bus_phase != BUS_IDLE);
        expected_ticks.push_back(r);
    endtask

    function automatic int field_mismatch(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic compare_tick(input t_result got);
        t_result want;
        int      bad;
        if (expected_ticks.size() == 0) begin
            $display("%0t ns: output beat with nothing expected, got %p", $time, got);
            o_failures++;
        end else begin
            want = expected_ticks.pop_front();
            bad  = field_mismatch("drive_low_mask", 16'(want.drive_low_mask),
                                  16'(got.drive_low_mask))
                 + field_mismatch("busy_res", 16'(want.busy_res), 16'(got.busy_res))
                 + field_mismatch("done_res", 16'(want.done_res), 16'(got.done_res))
                 + field_mismatch("presence_fail", 16'(want.presence_fail),
                                  16'(got.presence_fail))
                 + field_mismatch("temperature_raw", want.temperature_raw,
                                  got.temperature_raw);
            if (bad != 0) begin
                o_failures++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result got;
        if (!i_rst_n) begin
            timing     = TIMING_AT_RESET;
            bus_phase  = BUS_IDLE;
            tick_cnt   = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            temp_shift = '0;
            line       = '0;
            read_txn   = 1'b0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RESET_LOW:     timing.reset_low     = t_tick'(i_cfg_data);
                    CFG_PRESENCE_WAIT: timing.presence_wait = t_tick'(i_cfg_data);
                    CFG_SLOT_LOW:      timing.slot_low      = t_tick'(i_cfg_data);
                    CFG_WRITE_HOLD:    timing.write_hold    = t_tick'(i_cfg_data);
                    CFG_READ_SAMPLE:   timing.read_sample   = t_tick'(i_cfg_data);
                    CFG_BIT_GAP:       timing.bit_gap       = t_tick'(i_cfg_data);
                    CFG_BYTE_GAP:      timing.byte_gap      = t_tick'(i_cfg_data);
                    CFG_AFTER_RESET:   timing.after_reset   = t_tick'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                it.mode          = i_in.mode;
                it.sensor_select = i_in.sensor_select;
                it.line_levels   = i_in.line_levels;
                predict_tick(it);
            end
            if (i_out.valid && i_out.ready) begin
                got.drive_low_mask  = i_out.drive_low_mask;
                got.busy_res        = i_out.busy_res;
                got.done_res        = i_out.done_res;
                got.presence_fail   = i_out.presence_fail;
                got.temperature_raw = i_out.temperature_raw;
                compare_tick(got);
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

FILE: tb/onewire_temp_sensor_master_unit_tb.sv
module onewire_temp_sensor_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import otsm_pkg::*;
    import otsm_tb_pkg::*;

    // Cycles to let pass after the last expected beat before touching the registers;
    // this is comfortably clear of the block's input and result registers.
    localparam int SETTLE_CYCLES  = 8;
    // Length of the one deliberate receiver hold-off, in clock cycles.
    localparam int LONG_HOLD      = 400;
    // Cycles without any beat on either channel before the run is declared hung. The
    // longest legitimate quiet stretch is the hold-off above plus a long idle gap.
    localparam int WATCHDOG_LIMIT = 4000;

    // How the sampled line levels are chosen for each tick.
    typedef enum {
        LEVELS_NOISY,    // random, and now and then the presence pulse goes missing
        LEVELS_HIGH,     // every line high apart from the presence pulse
        LEVELS_LOW,      // every line low throughout
        LEVELS_ABSENT    // every line high throughout, so no sensor answers
    } t_levels;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int               failures;
    int               pending;
    logic             bus_idle;
    logic             presence_window;
    logic [SEL_W-1:0] active_line;

    bit      idling_on;
    bit      hold_request;
    t_levels level_policy;

    otsm_in_if  in_ch();
    otsm_out_if out_ch();

    onewire_temp_sensor_master_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // The checker watches both channels and the register port; besides the failure
    // count it tells the stimulus where the predicted bus state stands, so that line
    // levels can answer the reset pulse when a transaction is meant to go deep.
    otsm_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_failures        (failures),
        .o_pending         (pending),
        .o_bus_idle        (bus_idle),
        .o_presence_window (presence_window),
        .o_active_line     (active_line)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Most gaps are nil, a fair share are short, and a few are long.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 0;
        end
        if (roll < 97) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Levels for the next tick. The state the checker reports already reflects every
    // accepted beat, and that is exactly the state in which the next beat is applied.
    function automatic logic [LINE_W-1:0] pick_levels();
        logic [LINE_W-1:0] lv;
        lv = LINE_W'($urandom);
        case (level_policy)
            LEVELS_HIGH:   lv = '1;
            LEVELS_LOW:    lv = '0;
            LEVELS_ABSENT: lv = '1;
            default: ;
        endcase
        if (presence_window && level_policy != LEVELS_ABSENT
                && !(level_policy == LEVELS_NOISY && $urandom_range(0, 9) == 0)) begin
            lv[active_line] = 1'b0;
        end
        return lv;
    endfunction

    // Offers one tick and returns at the falling edge after it has been accepted. The
    // valid line is only lowered when a gap is wanted, so back-to-back beats keep it high
    // without a second assignment in the same time step.
    task automatic put_tick(input t_request req, input logic [SEL_W-1:0] sel);
        int gap;
        gap = idling_on ? idle_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= req;
        in_ch.sensor_select <= sel;
        in_ch.line_levels   <= pick_levels();
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Starts one request and keeps ticking until the predicted bus is idle again. The
    // ticks in between carry random requests, which the block must ignore while busy.
    task automatic run_request(input t_request req, input logic [SEL_W-1:0] sel);
        put_tick(req, sel);
        while (!bus_idle) begin
            put_tick(t_request'($urandom_range(0, 3)), SEL_W'($urandom));
        end
    endtask

    // Random traffic: from idle, mostly well-formed requests on a random line, with
    // some empty and reserved codes mixed in; while busy, mostly empty ticks.
    task automatic run_traffic(input int ticks);
        int       roll;
        t_request req;
        repeat (ticks) begin
            roll = $urandom_range(0, 99);
            if (bus_idle) begin
                req = roll < 42 ? REQ_CONVERT :
                      roll < 84 ? REQ_READ :
                      roll < 94 ? REQ_NONE : REQ_RESERVED;
            end else begin
                req = roll < 90 ? REQ_NONE : t_request'($urandom_range(1, 3));
            end
            put_tick(req, SEL_W'($urandom));
        end
    endtask

    // Brings the block to rest: finishes the transaction under way, stops offering,
    // waits for every owed beat and then for the settling margin, SETTLE_CYCLES.
    task automatic settle();
        while (!bus_idle) begin
            put_tick(REQ_NONE, SEL_W'($urandom));
        end
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_tick value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge i_clk);
    endtask

    task automatic load_setting(input t_cfg c);
        write_reg(CFG_RESET_LOW, c.reset_low);
        write_reg(CFG_PRESENCE_WAIT, c.presence_wait);
        write_reg(CFG_SLOT_LOW, c.slot_low);
        write_reg(CFG_WRITE_HOLD, c.write_hold);
        write_reg(CFG_READ_SAMPLE, c.read_sample);
        write_reg(CFG_BIT_GAP, c.bit_gap);
        write_reg(CFG_BYTE_GAP, c.byte_gap);
        write_reg(CFG_AFTER_RESET, c.after_reset);
        cfg_we <= 1'b0;
    endtask

    // Short slot and gap lengths, so that random traffic completes many transactions.
    function automatic t_cfg small_setting();
        t_cfg c;
        c.reset_low     = t_tick'($urandom_range(0, 6));
        c.presence_wait = t_tick'($urandom_range(0, 6));
        c.slot_low      = t_tick'($urandom_range(0, 6));
        c.write_hold    = t_tick'($urandom_range(0, 6));
        c.read_sample   = t_tick'($urandom_range(0, 6));
        c.bit_gap       = t_tick'($urandom_range(0, 6));
        c.byte_gap      = t_tick'($urandom_range(0, 6));
        c.after_reset   = t_tick'($urandom_range(0, 6));
        return c;
    endfunction

    // The receiver side. It idles at random while idling is enabled, and once, on
    // request, holds off for a long stretch so that the block backs up and stalls
    // the sender.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = idling_on ? idle_gap() : 0;
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Watchdog: a run in which no beat moves on either channel for too long is hung.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.mode          = REQ_NONE;
        in_ch.sensor_select = '0;
        in_ch.line_levels   = '0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_RESET_LOW;
        cfg_data            = '0;
        idling_on           = 1'b1;
        hold_request        = 1'b0;
        level_policy        = LEVELS_HIGH;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register values from reset: a read that nobody answers, which runs the full
        // reset pulse and presence wait at the standard microsecond timings.
        level_policy = LEVELS_ABSENT;
        run_request(REQ_READ, 2'd1);
        level_policy = LEVELS_HIGH;
        settle();

        // Every length at zero, so that each phase lasts a single tick. Covers both
        // commands, a read of all ones and one of all zeros, a missing presence pulse
        // and the empty and reserved request codes.
        load_setting('0);
        run_request(REQ_CONVERT, 2'd0);
        run_request(REQ_READ, 2'd3);
        level_policy = LEVELS_LOW;
        run_request(REQ_READ, 2'd1);
        level_policy = LEVELS_ABSENT;
        run_request(REQ_CONVERT, 2'd2);
        put_tick(REQ_RESERVED, 2'd0);
        put_tick(REQ_NONE, 2'd3);

        // Random traffic under several short timing sets. One set runs with no idling
        // on either side, and during another the receiver holds off for a long while.
        level_policy = LEVELS_NOISY;
        for (int set_no = 0; set_no < 4; set_no++) begin
            settle();
            load_setting(small_setting());
            idling_on = (set_no != 3);
            if (set_no == 2) begin
                hold_request = 1'b1;
            end
            run_traffic(150);
        end
        settle();

        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: onewire_temp_sensor_master_unit.f
hdl/otsm_pkg.sv
hdl/otsm_if.sv
hdl/otsm_cfg.sv
hdl/otsm_ctrl.sv
hdl/onewire_temp_sensor_master_unit.sv
tb/otsm_tb_pkg.sv
tb/otsm_checker.sv
tb/onewire_temp_sensor_master_unit_tb.sv
